// File: rtl/kss_pkg.sv
// kss_pkg: shared constants, codes and types of the knot span search block
// used by kss_knot_ram, kss_search_ctrl and knot_span_search
// no dependencies
package kss_pkg;

    localparam int MAX_KNOTS = 64;
    localparam int IDX_W     = $clog2(MAX_KNOTS);   // store address width
    localparam int SIDX_W    = IDX_W + 1;           // search index, reaches MAX_KNOTS
    localparam int KNOT_W    = 32;
    localparam int DEG_W     = 4;
    localparam int CNT_W     = 7;
    localparam int SPAN_W    = 6;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 7;

    // item modes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_FOUND   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_WRITTEN = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_CFG = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEGREE     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KNOT_COUNT = 1'd1;

    // knot store access from the sequencer
    typedef struct packed {
        logic                  wr_en;
        logic [IDX_W-1:0]      wr_addr;
        logic [KNOT_W-1:0]     wr_data;
        logic [SIDX_W-1:0]     rd_addr_a;
        logic [SIDX_W-1:0]     rd_addr_b;
    } kss_ram_req_t;

endpackage

// File: rtl/knot_span_search.sv
// knot_span_search: top level of the knot span search block
// holds configuration registers and the output register
// depends on kss_pkg, kss_knot_ram, kss_search_ctrl
//
// usage
// - input channel (in_valid/in_ready) carries one transaction per item:
//   mode 0 stores param_value as knot knot_index, mode 1 looks up the
//   span of param_value in the sorted knot vector
// - output channel (out_valid/out_ready) returns one transaction per item:
//   span_index and status (0 found, 1 written, 2 bad configuration)
// - cfg_wr_en writes cfg_data into register cfg_index (0 degree,
//   1 knot_count); write only while no item is in flight
// - sequence: a write or a flagged query goes from acceptance to ST_DONE
//   and then through the output register to out_valid; a query passes
//   ST_EDGE for the edge checks, then ST_SEARCH once per binary search step
// - one item is worked at a time (in_ready only in ST_IDLE); each search
//   step waits on the registered read
// - the output register lets the next item be accepted while a result
//   waits; when the receiver stalls, at most one more result is finished
//   and then in_ready stays low until the output register drains
// - reset clears control state and sets degree 3, knot_count 8; the knot
//   store is not cleared and a knot must be written before it is searched
module knot_span_search (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [kss_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kss_pkg::CFG_W-1:0]       cfg_data,
    // input channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            mode,
    input  logic [kss_pkg::IDX_W-1:0]       knot_index,
    input  logic [kss_pkg::KNOT_W-1:0]      param_value,
    // output channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [kss_pkg::SPAN_W-1:0]      span_index,
    output logic [kss_pkg::STATUS_W-1:0]    status
);

    logic [kss_pkg::DEG_W-1:0]      degree_reg;
    logic [kss_pkg::CNT_W-1:0]      knot_count_reg;

    logic                           out_valid_reg;
    logic [kss_pkg::SPAN_W-1:0]     span_index_reg;
    logic [kss_pkg::STATUS_W-1:0]   status_reg;

    kss_pkg::kss_ram_req_t          ram_req;
    logic [kss_pkg::KNOT_W-1:0]     rd_data_a;
    logic [kss_pkg::KNOT_W-1:0]     rd_data_b;

    logic                           res_valid;
    logic                           res_ready;
    logic [kss_pkg::SPAN_W-1:0]     res_span;
    logic [kss_pkg::STATUS_W-1:0]   res_status;

    // configuration registers, values masked to register width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg     <= kss_pkg::DEG_W'(3);
            knot_count_reg <= kss_pkg::CNT_W'(8);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                kss_pkg::REG_DEGREE:     degree_reg     <= cfg_data[kss_pkg::DEG_W-1:0];
                kss_pkg::REG_KNOT_COUNT: knot_count_reg <= cfg_data[kss_pkg::CNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // knot store
    kss_knot_ram u_ram (
        .clk       (clk),
        .req       (ram_req),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // sequencer: writes, edge checks and the search loop
    kss_search_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .knot_index  (knot_index),
        .param_value (param_value),
        .degree      (degree_reg),
        .knot_count  (knot_count_reg),
        .ram_req     (ram_req),
        .rd_data_a   (rd_data_a),
        .rd_data_b   (rd_data_b),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_span    (res_span),
        .res_status  (res_status)
    );

    // output register: takes a result when empty or being drained
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            span_index_reg <= res_span;
            status_reg     <= res_status;
        end
    end

    assign out_valid  = out_valid_reg;
    assign span_index = span_index_reg;
    assign status     = status_reg;

endmodule

// File: rtl/kss_knot_ram.sv
// kss_knot_ram: knot store, one write port and two registered read ports
// reads at an index past the store give zero
// depends on kss_pkg
module kss_knot_ram (
    input  logic                        clk,
    input  kss_pkg::kss_ram_req_t       req,
    output logic [kss_pkg::KNOT_W-1:0]  rd_data_a,
    output logic [kss_pkg::KNOT_W-1:0]  rd_data_b
);

    logic [kss_pkg::KNOT_W-1:0] mem [kss_pkg::MAX_KNOTS];
    logic [kss_pkg::KNOT_W-1:0] data_a_reg;
    logic [kss_pkg::KNOT_W-1:0] data_b_reg;
    logic                       zero_a_reg;
    logic                       zero_b_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        data_a_reg <= mem[req.rd_addr_a[kss_pkg::IDX_W-1:0]];
        data_b_reg <= mem[req.rd_addr_b[kss_pkg::IDX_W-1:0]];
        zero_a_reg <= req.rd_addr_a[kss_pkg::IDX_W];
        zero_b_reg <= req.rd_addr_b[kss_pkg::IDX_W];
    end

    assign rd_data_a = zero_a_reg ? '0 : data_a_reg;
    assign rd_data_b = zero_b_reg ? '0 : data_b_reg;

endmodule

// File: rtl/kss_search_ctrl.sv
// kss_search_ctrl: item sequencer, knot writes, edge checks and binary search
// drives the knot store read and write ports
// depends on kss_pkg
module kss_search_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            mode,
    input  logic [kss_pkg::IDX_W-1:0]       knot_index,
    input  logic [kss_pkg::KNOT_W-1:0]      param_value,
    input  logic [kss_pkg::DEG_W-1:0]       degree,
    input  logic [kss_pkg::CNT_W-1:0]       knot_count,
    output kss_pkg::kss_ram_req_t           ram_req,
    input  logic [kss_pkg::KNOT_W-1:0]      rd_data_a,
    input  logic [kss_pkg::KNOT_W-1:0]      rd_data_b,
    output logic                            res_valid,
    input  logic                            res_ready,
    output logic [kss_pkg::SPAN_W-1:0]      res_span,
    output logic [kss_pkg::STATUS_W-1:0]    res_status
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_EDGE   = 2'd1;
    localparam logic [1:0] ST_SEARCH = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    localparam int SIDX_W = kss_pkg::SIDX_W;

    logic [1:0]                     state_reg,  state_next;
    logic [kss_pkg::KNOT_W-1:0]     u_reg,      u_next;
    logic [SIDX_W-1:0]              deg_reg,    deg_next;
    logic [SIDX_W-1:0]              dof_reg,    dof_next;
    logic [SIDX_W-1:0]              low_reg,    low_next;
    logic [SIDX_W-1:0]              high_reg,   high_next;
    logic [SIDX_W-1:0]              mid_reg,    mid_next;
    logic [kss_pkg::SPAN_W-1:0]     span_reg,   span_next;
    logic [kss_pkg::STATUS_W-1:0]   status_reg, status_next;

    logic                           accept;
    logic                           cfg_bad;
    logic [SIDX_W-1:0]              dof_now;
    logic [SIDX_W-1:0]              deg_now;
    logic [SIDX_W-1:0]              min_count;
    logic [SIDX_W:0]                mid_sum;
    logic [SIDX_W-1:0]              range;
    logic                           u_below_a;
    logic                           u_below_b;
    logic                           u_le_b;
    logic [SIDX_W-1:0]              rd_addr;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);

    // configuration check and degrees of freedom
    assign deg_now   = SIDX_W'(degree);
    assign dof_now   = knot_count - deg_now - SIDX_W'(1);
    assign min_count = {deg_now[SIDX_W-2:0], 1'b0} + SIDX_W'(2);
    assign cfg_bad   = (knot_count > SIDX_W'(kss_pkg::MAX_KNOTS)) || (knot_count < min_count);

    assign u_below_a = $signed(u_reg) < $signed(rd_data_a);
    assign u_below_b = $signed(u_reg) < $signed(rd_data_b);
    assign u_le_b    = !($signed(u_reg) > $signed(rd_data_b));
    assign range     = high_reg - low_reg;

    always_comb
    begin
        state_next  = state_reg;
        u_next      = u_reg;
        deg_next    = deg_reg;
        dof_next    = dof_reg;
        low_next    = low_reg;
        high_next   = high_reg;
        mid_next    = mid_reg;
        span_next   = span_reg;
        status_next = status_reg;
        mid_sum     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    u_next   = param_value;
                    deg_next = deg_now;
                    dof_next = dof_now;
                    if (mode == kss_pkg::MODE_WRITE)
                    begin
                        span_next   = '0;
                        status_next = kss_pkg::STATUS_WRITTEN;
                        state_next  = ST_DONE;
                    end
                    else if (cfg_bad)
                    begin
                        span_next   = '0;
                        status_next = kss_pkg::STATUS_BAD_CFG;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        status_next = kss_pkg::STATUS_FOUND;
                        state_next  = ST_EDGE;
                    end
                end
            end
            ST_EDGE:
            begin
                // port a holds knot[dof], port b holds knot[degree]
                if (!u_below_a)
                begin
                    span_next  = kss_pkg::SPAN_W'(dof_reg - SIDX_W'(1));
                    state_next = ST_DONE;
                end
                else if (u_le_b)
                begin
                    span_next  = kss_pkg::SPAN_W'(deg_reg);
                    state_next = ST_DONE;
                end
                else
                begin
                    low_next   = '0;
                    high_next  = dof_reg + SIDX_W'(1);
                    mid_sum    = {1'b0, high_next};
                    mid_next   = mid_sum[SIDX_W:1];
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                // port a holds knot[mid], port b holds knot[mid+1]
                if ((!u_below_a && u_below_b) || (range <= SIDX_W'(1)))
                begin
                    span_next  = kss_pkg::SPAN_W'(mid_reg);
                    state_next = ST_DONE;
                end
                else
                begin
                    if (u_below_a)
                    begin
                        high_next = mid_reg;
                    end
                    else
                    begin
                        low_next = mid_reg;
                    end
                    mid_sum  = {1'b0, low_next} + {1'b0, high_next};
                    mid_next = mid_sum[SIDX_W:1];
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // read the edge knots in idle, else the knots at the next search point
    always_comb
    begin
        rd_addr = mid_next;
        ram_req.wr_en     = accept && (mode == kss_pkg::MODE_WRITE);
        ram_req.wr_addr   = knot_index;
        ram_req.wr_data   = param_value;
        if (state_reg == ST_IDLE)
        begin
            ram_req.rd_addr_a = dof_now;
            ram_req.rd_addr_b = deg_now;
        end
        else
        begin
            ram_req.rd_addr_a = rd_addr;
            ram_req.rd_addr_b = rd_addr + SIDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg      <= u_next;
        deg_reg    <= deg_next;
        dof_reg    <= dof_next;
        low_reg    <= low_next;
        high_reg   <= high_next;
        mid_reg    <= mid_next;
        span_reg   <= span_next;
        status_reg <= status_next;
    end

    assign res_valid  = (state_reg == ST_DONE);
    assign res_span   = span_reg;
    assign res_status = status_reg;

endmodule

// File: verif/tb_knot_span_search.sv
// tb_knot_span_search: self-checking testbench of the knot span search block
// drives knot writes and span queries, predicts every result and checks it
// depends on kss_pkg and knot_span_search
module tb_knot_span_search;
    timeunit 1ns;
    timeprecision 1ps;

    import kss_pkg::*;

    // run shape
    localparam int ITEM_TARGET = 1850;   // stimulus stops once this many are queued
    localparam int DRAIN_CYCLES = 12;     // extra wait after every result is back
    localparam int TAIL_CYCLES = 20;      // quiet time after the last result
    localparam int STUCK_LIMIT = 2000;    // cycles with no transaction before giving up
    localparam int IDLE_PCT = 15;         // chance of a gap or stall per cycle
    localparam int CALM_LO = 700;         // window with no gaps and no stalls
    localparam int CALM_HI = 1000;
    localparam int PRINT_CAP = 100;

    localparam logic [KNOT_W-1:0] KNOT_MIN = 32'h8000_0000;
    localparam logic [KNOT_W-1:0] KNOT_MAX = 32'h7FFF_FFFF;
    localparam longint KNOT_LO = -64'sd2147483648;

    typedef struct packed {
        logic              mode;
        logic [IDX_W-1:0]  knot_index;
        logic [KNOT_W-1:0] param_value;
    } knot_op_t;

    typedef struct packed {
        logic [SPAN_W-1:0]   span_index;
        logic [STATUS_W-1:0] status;
    } span_result_t;

    // block ports; the driven inputs are known from time zero
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  mode = MODE_WRITE;
    logic [IDX_W-1:0]      knot_index = '0;
    logic [KNOT_W-1:0]     param_value = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [SPAN_W-1:0]     span_index;
    logic [STATUS_W-1:0]   status;

    // items waiting for the driver and spans waiting for the output side
    knot_op_t     knot_ops_q [$];
    span_result_t spans_due_q [$];

    // predictor copy of the store and the registers
    logic [KNOT_W-1:0] model_knots [MAX_KNOTS];
    logic [DEG_W-1:0]  model_degree = 4'd3;
    logic [CNT_W-1:0]  model_count = 7'd8;

    // what the stimulus generator believes the store and registers hold
    logic [KNOT_W-1:0] gen_knots [MAX_KNOTS];
    int                gen_degree = 3;
    int                gen_count = 8;
    int                ops_queued = 0;

    // bookkeeping shared by driver, monitor and watchdog
    bit           in_took = 1'b0;
    bit           out_took = 1'b0;
    int           ops_taken = 0;
    int           results_seen = 0;
    int           stuck_cycles = 0;
    int           mismatch_cnt = 0;
    knot_op_t     next_op;
    span_result_t due_res;

    knot_span_search dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .knot_index (knot_index),
        .param_value(param_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .span_index (span_index),
        .status     (status)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // positions past the store read as zero
    function automatic logic signed [KNOT_W-1:0] knot_value(input int unsigned pos);
        if (pos >= MAX_KNOTS)
            return '0;
        return model_knots[pos];
    endfunction

    // expected result of one transaction; a knot write also updates the store copy
    function automatic span_result_t predict_span(input knot_op_t op);
        span_result_t             res;
        int unsigned              deg;
        int unsigned              dof;
        int unsigned              lo;
        int unsigned              hi;
        int unsigned              mid;
        logic signed [KNOT_W-1:0] u;
        res = '0;
        if (op.mode == MODE_WRITE) begin
            model_knots[op.knot_index] = op.param_value;
            res.status = STATUS_WRITTEN;
            return res;
        end
        deg = model_degree;
        // too few knots for the degree, or more than the store holds
        if (model_count > MAX_KNOTS || model_count < 2 * deg + 2) begin
            res.status = STATUS_BAD_CFG;
            return res;
        end
        dof = model_count - deg - 1;
        u = op.param_value;
        if (u >= knot_value(dof)) begin
            mid = dof - 1;
        end
        else if (u <= knot_value(deg)) begin
            mid = deg;
        end
        else begin
            lo = 0;
            hi = dof + 1;
            mid = (lo + hi) / 2;
            // an unsorted store ends the search once the window is one wide
            while (u < knot_value(mid) || u >= knot_value(mid + 1)) begin
                if (hi - lo <= 1)
                    break;
                if (u < knot_value(mid))
                    hi = mid;
                else
                    lo = mid;
                mid = (lo + hi) / 2;
            end
        end
        res.status = STATUS_FOUND;
        res.span_index = mid[SPAN_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_cnt < PRINT_CAP)
            $display("ERROR at %0t ns: %s", $realtime, msg);
        mismatch_cnt++;
    endtask

    // ------------------------------------------------------------------
    // driver: one transaction at a time from the pending queue, random gaps
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else if (in_valid && !in_took) begin
            // transaction still offered, hold valid and payload
        end
        else if (knot_ops_q.size() != 0 &&
                 ((ops_taken >= CALM_LO && ops_taken < CALM_HI) ||
                  $urandom_range(0, 99) >= IDLE_PCT)) begin
            next_op = knot_ops_q.pop_front();
            in_valid    <= 1'b1;
            mode        <= next_op.mode;
            knot_index  <= next_op.knot_index;
            param_value <= next_op.param_value;
        end
        else begin
            in_valid <= 1'b0;
        end
    end

    // receiver stalls, with a calm window in the middle of the run
    always @(negedge clk) begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= (results_seen >= CALM_LO && results_seen < CALM_HI) ||
                         ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------
    // monitor: register writes, accepted items, results and the watchdog
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        in_took = in_valid && in_ready;
        out_took = out_valid && out_ready;
        if (rst_n) begin
            if (cfg_wr_en) begin
                // register values are cut to the register width
                if (cfg_index == REG_DEGREE)
                    model_degree = cfg_data[DEG_W-1:0];
                else if (cfg_index == REG_KNOT_COUNT)
                    model_count = cfg_data[CNT_W-1:0];
            end
            if (in_took) begin
                spans_due_q.insert(spans_due_q.size(),
                                   predict_span('{mode, knot_index, param_value}));
                ops_taken++;
            end
            if (out_took) begin
                results_seen++;
                if (spans_due_q.size() == 0) begin
                    report_mismatch($sformatf("result with nothing pending: span %0d status %0d",
                                              span_index, status));
                end
                else begin
                    due_res = spans_due_q.pop_front();
                    if (span_index !== due_res.span_index)
                        report_mismatch($sformatf("span_index %0d, predicted %0d (result %0d)",
                                                  span_index, due_res.span_index, results_seen));
                    if (status !== due_res.status)
                        report_mismatch($sformatf("status %0d, predicted %0d (result %0d)",
                                                  status, due_res.status, results_seen));
                end
            end
            if (in_took || out_took) begin
                stuck_cycles = 0;
            end
            else begin
                stuck_cycles++;
                if (stuck_cycles >= STUCK_LIMIT) begin
                    $display("watchdog: no transaction for %0d cycles", STUCK_LIMIT);
                    $display("DONE: errors detected");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus generation
    // ------------------------------------------------------------------

    task automatic queue_op(input logic m, input int unsigned idx, input logic [KNOT_W-1:0] val);
        knot_op_t op;
        op.mode = m;
        op.knot_index = idx[IDX_W-1:0];
        op.param_value = val;
        if (m == MODE_WRITE)
            gen_knots[op.knot_index] = val;
        knot_ops_q.insert(knot_ops_q.size(), op);
        ops_queued++;
    endtask

    function automatic bit gen_good();
        return gen_count <= MAX_KNOTS && gen_count >= 2 * gen_degree + 2;
    endfunction

    // block is idle: nothing pending, nothing offered, every result back
    task automatic wait_drained();
        while (knot_ops_q.size() != 0 || in_valid || spans_due_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // registers change only while idle; spare data bits above degree get noise
    task automatic write_config(input logic [DEG_W-1:0] deg, input logic [CNT_W-1:0] kc);
        logic [CFG_W-DEG_W-1:0] pad;
        pad = (CFG_W-DEG_W)'($urandom);
        wait_drained();
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = REG_DEGREE;
        cfg_data = {pad, deg};
        @(negedge clk);
        cfg_index = REG_KNOT_COUNT;
        cfg_data = kc;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        gen_degree = int'(deg);
        gen_count = int'(kc);
    endtask

    // fill positions 0..n-1, mostly sorted with repeats, sometimes clamped ends
    task automatic load_knots(input int n);
        logic [KNOT_W-1:0] vals [MAX_KNOTS];
        int unsigned       step_max;
        int unsigned       step;
        longint            room;
        longint            cur;
        int                style;
        int                i;
        style = $urandom_range(0, 9);
        if (style == 0) begin
            // unsorted store
            for (i = 0; i < n; i++)
                vals[i] = $urandom;
        end
        else begin
            if ($urandom_range(0, 3) == 0)
                step_max = $urandom_range(1, 4096);
            else
                step_max = 32'hFFFF_FFFF / (n + 1);
            room = 64'd4294967295 - longint'(step_max) * longint'(n);
            cur = KNOT_LO + (longint'($urandom) % room);
            for (i = 0; i < n; i++) begin
                step = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, step_max);
                cur = cur + longint'(step);
                vals[i] = cur[KNOT_W-1:0];
            end
            // clamped vector: degree+1 equal knots at both ends
            if (style <= 4) begin
                for (i = 1; i <= gen_degree; i++)
                    vals[i] = vals[0];
                for (i = gen_count - gen_degree - 1; i < gen_count; i++)
                    vals[i] = vals[gen_count - 1];
            end
            if (style == 9) begin
                vals[0] = KNOT_MIN;
                vals[n-1] = KNOT_MAX;
            end
        end
        if ($urandom_range(0, 3) == 0) begin
            for (i = n - 1; i >= 0; i--)
                queue_op(MODE_WRITE, i, vals[i]);
        end
        else begin
            for (i = 0; i < n; i++)
                queue_op(MODE_WRITE, i, vals[i]);
        end
    endtask

    // query values: extremes, exact knots, knot +-1, midpoints, anything
    task automatic queue_query();
        logic [KNOT_W-1:0] val;
        int unsigned       pick;
        int unsigned       pos;
        longint            mid_sum;
        pick = $urandom_range(0, 9);
        pos = 0;
        if (gen_good())
            pos = $urandom_range(0, gen_count - 2);
        else
            pick = ($urandom_range(0, 4) == 0) ? 0 : 9;
        case (pick)
            0: val = $urandom_range(0, 1) ? KNOT_MIN : KNOT_MAX;
            1, 2, 3: val = gen_knots[pos + $urandom_range(0, 1)];
            4: val = gen_knots[pos] + ($urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF);
            5, 6, 7:
            begin
                mid_sum = longint'($signed(gen_knots[pos])) +
                          longint'($signed(gen_knots[pos + 1]));
                mid_sum = mid_sum >>> 1;
                val = mid_sum[KNOT_W-1:0];
            end
            default: val = $urandom;
        endcase
        queue_op(MODE_QUERY, $urandom_range(0, 63), val);
    endtask

    initial begin
        int          phase;
        int          nq;
        int          k;
        logic [DEG_W-1:0] deg;
        logic [CNT_W-1:0] kc;

        for (k = 0; k < MAX_KNOTS; k++)
            gen_knots[k] = '0;

        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // directed part at the reset setting: degree 3, 8 knots, extremes at the ends
        queue_op(MODE_WRITE, 0, KNOT_MIN);
        queue_op(MODE_WRITE, 1, 32'hFFFD_0000);   // -3.0
        queue_op(MODE_WRITE, 2, 32'hFFFF_0000);   // -1.0
        queue_op(MODE_WRITE, 3, 32'h0000_0000);   // 0.0, knot at the degree
        queue_op(MODE_WRITE, 4, 32'h0001_0000);   // 1.0, knot at dof
        queue_op(MODE_WRITE, 5, 32'h0002_8000);   // 2.5
        queue_op(MODE_WRITE, 6, 32'h0004_0000);   // 4.0
        queue_op(MODE_WRITE, 7, KNOT_MAX);
        queue_op(MODE_QUERY, 63, KNOT_MAX);       // above the last span
        queue_op(MODE_QUERY, 0, KNOT_MIN);        // below the first span
        queue_op(MODE_QUERY, 21, 32'h0000_0000);  // exactly on the low boundary
        queue_op(MODE_QUERY, 42, 32'h0001_0000);  // exactly on the high boundary
        queue_op(MODE_QUERY, 5, 32'h0000_8000);
        queue_op(MODE_QUERY, 58, 32'h0000_FFFF);
        queue_op(MODE_QUERY, 9, 32'hFFFF_FFFF);

        // degree 1 opens several interior spans for the binary search
        write_config(4'd1, 7'd8);
        queue_op(MODE_QUERY, 0, 32'hFFFF_0000);   // exactly on an interior knot
        queue_op(MODE_QUERY, 0, 32'h0003_0000);
        queue_op(MODE_QUERY, 0, 32'h0002_8000);
        queue_op(MODE_QUERY, 0, 32'h0000_8000);

        // too few knots for the degree; a write still goes through
        write_config(4'd15, 7'd8);
        queue_op(MODE_QUERY, 0, 32'h0000_4000);
        queue_op(MODE_WRITE, 7, KNOT_MAX);

        // unsorted store: knot 3 is set far above its neighbours before a query
        write_config(4'd1, 7'd8);
        queue_op(MODE_WRITE, 3, 32'h7FFF_0000);
        queue_op(MODE_QUERY, 0, 32'h0000_4000);

        // random phases: a setting, a knot vector, then queries with some noise
        phase = 0;
        while (ops_queued < ITEM_TARGET) begin
            case (phase)
                0: begin deg = 4'd0;  kc = 7'd2;   end
                1: begin deg = 4'd15; kc = 7'd64;  end
                2: begin deg = 4'd15; kc = 7'd127; end
                3: begin deg = 4'd0;  kc = 7'd64;  end
                default:
                begin
                    case ($urandom_range(0, 9))
                        0:
                        begin
                            deg = DEG_W'($urandom_range(0, 15));
                            kc = CNT_W'($urandom_range(MAX_KNOTS + 1, 127));
                        end
                        1:
                        begin
                            deg = DEG_W'($urandom_range(0, 15));
                            kc = CNT_W'($urandom_range(0, 2 * deg + 1));
                        end
                        2:
                        begin
                            deg = DEG_W'($urandom_range(8, 15));
                            kc = CNT_W'($urandom_range(2 * deg + 2, MAX_KNOTS));
                        end
                        default:
                        begin
                            deg = DEG_W'($urandom_range(0, 5));
                            kc = CNT_W'($urandom_range(2 * deg + 2, 2 * deg + 18));
                        end
                    endcase
                end
            endcase
            write_config(deg, kc);
            if (gen_good()) begin
                // one extra knot so a degree 0 search never reads an unwritten entry
                load_knots(gen_count < MAX_KNOTS ? gen_count + 1 : MAX_KNOTS);
                nq = $urandom_range(20, 60);
            end
            else begin
                nq = $urandom_range(10, 25);
            end
            repeat (nq) begin
                if ($urandom_range(0, 99) < 8)
                    queue_op(MODE_WRITE, $urandom_range(0, 63), $urandom);
                else
                    queue_query();
            end
            phase++;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
